@@ rtl/msapc_pkg.sv @@
// Shared constants, types and the counter address function for the
// pair-count histogram. No dependencies.
package msapc_pkg;

    localparam int MAX_COLS    = 8;
    localparam int ALPHABET    = 21;
    localparam int COUNT_WIDTH = 16;

    localparam int OP_W    = 2;
    localparam int SYM_W   = 5;
    localparam int COL_W   = 3;
    localparam int CFG_W   = 4;
    localparam int VAL_W   = 16;
    localparam int ROWS_W  = 16;

    localparam int SQ_ALPHA     = ALPHABET * ALPHABET;
    localparam int NUM_COUNTERS = MAX_COLS * MAX_COLS * SQ_ALPHA;
    localparam int ADDR_W       = $clog2(NUM_COUNTERS);
    // one spare bit so an out-of-range slot can be detected
    localparam int SLOT_W       = ADDR_W + 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [ROWS_W-1:0]      ROWS_MAX  = '1;
    localparam logic [CFG_W-1:0]       CFG_RESET = CFG_W'(MAX_COLS);

    // op codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // result source select
    localparam logic [1:0] SRC_NOW   = 2'd0;
    localparam logic [1:0] SRC_READ  = 2'd1;
    localparam logic [1:0] SRC_TALLY = 2'd2;
    localparam logic [1:0] SRC_CLEAR = 2'd3;

    typedef struct packed {
        logic       accept;
        logic       tally_step;
        logic       sweep_step;
        logic       out_load;
        logic [1:0] out_src;
    } cmd_t;

    typedef struct packed {
        logic in_tally;
        logic in_read;
        logic in_clear;
        logic tally_last;
        logic sweep_last;
    } sts_t;

    function automatic logic [SLOT_W-1:0] slot(
        input logic [COL_W-1:0] ci,
        input logic [COL_W-1:0] cj,
        input logic [SYM_W-1:0] sa,
        input logic [SYM_W-1:0] sb
    );
        logic [SLOT_W-1:0] pair;
        pair = SLOT_W'(ci) * SLOT_W'(MAX_COLS) + SLOT_W'(cj);
        slot = pair * SLOT_W'(SQ_ALPHA) + SLOT_W'(sa) * SLOT_W'(ALPHABET) + SLOT_W'(sb);
    endfunction

endpackage

@@ rtl/msa_pair_count_histogram.sv @@
// On acceptance a non-final push or rejected word loads its result directly; a good
//   read waits on the registered counter read; a row-finishing push walks cols*cols
//   pairs, one counter read-modify-write per cycle; clear zeroes all, one per cycle.
// Throughput: one word in flight; the next word is taken as the result leaves.
// Reset: aresetn synchronous, active low; after release all 28224 counters are
//   cleared with s_tready low, cfg_we still taken. Columns register resets to 8.
module msa_pair_count_histogram (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: columns in use
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // symbol[4:0] col_i[7:5] col_j[10:8]
                                   // sym_a[15:11] sym_b[20:16], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // count_value[15:0] rows_seen[31:16]
    output logic        m_tlast,   // row_complete
    output logic        m_tuser    // error
);

    msapc_pkg::cmd_t cmd;
    msapc_pkg::sts_t sts;

    logic [msapc_pkg::VAL_W-1:0]  out_count;
    logic [msapc_pkg::ROWS_W-1:0] out_rows;

    // FSM: handshake, read wait, tally walk, clear sweep
    msapc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // row buffer, counter memory, result register
    msapc_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_op        (s_tuser),
        .in_symbol    (s_tdata[4:0]),
        .in_col_i     (s_tdata[7:5]),
        .in_col_j     (s_tdata[10:8]),
        .in_sym_a     (s_tdata[15:11]),
        .in_sym_b     (s_tdata[20:16]),
        .cmd          (cmd),
        .sts          (sts),
        .out_count    (out_count),
        .out_complete (m_tlast),
        .out_rows     (out_rows),
        .out_error    (m_tuser)
    );

    assign m_tdata = {out_rows, out_count};

`ifndef SYNTH
    // an accepted word never overwrites an untaken result
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input accepted while result pending");

    // a loaded result is presented next cycle
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result load lost");

    // tally walk ends after its last pair
    a_tally_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tally_step && sts.tally_last) |=> !cmd.tally_step)
        else $error("tally ran past last pair");

    // sweep and tally never share the write port
    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_step |-> (!cmd.tally_step && !$past(cmd.tally_step)))
        else $error("sweep overlaps tally write-back");
`endif

endmodule

@@ rtl/msapc_ctrl.sv @@
// Sequencer for the pair-count histogram: handshake, read wait, tally, clear sweep.
// Depends on msapc_pkg.
module msapc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  msapc_pkg::sts_t     sts,
    output msapc_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_TALLY = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tready && s_tvalid;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (sts.in_tally) begin
                        state_next = ST_TALLY;
                    end else if (sts.in_read) begin
                        state_next = ST_READ;
                    end else if (sts.in_clear) begin
                        state_next = ST_CLEAR;
                    end else begin
                        cmd.out_load = 1'b1;
                        cmd.out_src  = msapc_pkg::SRC_NOW;
                    end
                end
            end
            ST_READ: begin
                cmd.out_load = 1'b1;
                cmd.out_src  = msapc_pkg::SRC_READ;
                state_next   = ST_IDLE;
            end
            ST_TALLY: begin
                cmd.tally_step = 1'b1;
                if (sts.tally_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last write-back lands this cycle
                cmd.out_load = 1'b1;
                cmd.out_src  = msapc_pkg::SRC_TALLY;
                state_next   = ST_IDLE;
            end
            ST_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = msapc_pkg::SRC_CLEAR;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/msapc_dp.sv @@
// Datapath for the pair-count histogram: row buffer, scan lines, counter
// memory with read-modify-write, row total and result register. Uses msapc_pkg.
module msapc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [msapc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [msapc_pkg::OP_W-1:0]          in_op,
    input  logic [msapc_pkg::SYM_W-1:0]         in_symbol,
    input  logic [msapc_pkg::COL_W-1:0]         in_col_i,
    input  logic [msapc_pkg::COL_W-1:0]         in_col_j,
    input  logic [msapc_pkg::SYM_W-1:0]         in_sym_a,
    input  logic [msapc_pkg::SYM_W-1:0]         in_sym_b,
    input  msapc_pkg::cmd_t                     cmd,
    output msapc_pkg::sts_t                     sts,
    output logic [msapc_pkg::VAL_W-1:0]         out_count,
    output logic                                out_complete,
    output logic [msapc_pkg::ROWS_W-1:0]        out_rows,
    output logic                                out_error
);

    localparam int CW = msapc_pkg::CFG_W;
    localparam int SW = msapc_pkg::SYM_W;
    localparam int AW = msapc_pkg::ADDR_W;
    localparam int NC = msapc_pkg::MAX_COLS;

    logic [CW-1:0]                        cfg_reg;
    logic [CW-1:0]                        cols;
    logic [msapc_pkg::COL_W-1:0]          fill_reg;
    logic [SW-1:0]                        row_reg   [NC];
    logic [SW-1:0]                        row_new   [NC];
    logic [SW-1:0]                        iscan_reg [NC];
    logic [SW-1:0]                        jscan_reg [NC];
    logic [msapc_pkg::COL_W-1:0]          i_reg, j_reg;
    logic [msapc_pkg::ROWS_W-1:0]         rows_reg;
    logic [AW-1:0]                        sweep_reg;
    logic [msapc_pkg::COUNT_WIDTH-1:0]    mem [msapc_pkg::NUM_COUNTERS];
    logic [msapc_pkg::COUNT_WIDTH-1:0]    rdata_reg;
    logic [msapc_pkg::COUNT_WIDTH-1:0]    wb_data;
    logic                                 wb_valid_reg;
    logic [AW-1:0]                        wb_addr_reg;

    logic                                 sym_ok, push_ok, push_done, read_ok, err_now;
    logic                                 j_wrap;
    logic [msapc_pkg::SLOT_W-1:0]         rd_slot;
    logic                                 rd_en, mem_we;
    logic [AW-1:0]                        mem_waddr;
    logic [msapc_pkg::COUNT_WIDTH-1:0]    mem_wdata;

    // column register clamped to 1..MAX_COLS
    always_comb begin
        if (cfg_reg == '0) begin
            cols = CW'(1);
        end else if (cfg_reg > CW'(NC)) begin
            cols = CW'(NC);
        end else begin
            cols = cfg_reg;
        end
    end

    // item decode
    assign sym_ok    = in_symbol < SW'(msapc_pkg::ALPHABET);
    assign push_ok   = (in_op == msapc_pkg::OP_PUSH) && sym_ok;
    assign push_done = (CW'(fill_reg) + CW'(1)) >= cols;
    assign read_ok   = (in_op == msapc_pkg::OP_READ)
                    && (CW'(in_col_i) < cols) && (CW'(in_col_j) < cols)
                    && (in_sym_a < SW'(msapc_pkg::ALPHABET))
                    && (in_sym_b < SW'(msapc_pkg::ALPHABET));
    assign err_now   = ((in_op == msapc_pkg::OP_PUSH) && !sym_ok)
                    || ((in_op == msapc_pkg::OP_READ) && !read_ok)
                    || ((in_op != msapc_pkg::OP_PUSH) && (in_op != msapc_pkg::OP_READ)
                        && (in_op != msapc_pkg::OP_CLEAR));

    assign j_wrap = (CW'(j_reg) + CW'(1)) == cols;

    assign sts.in_tally   = push_ok && push_done;
    assign sts.in_read    = read_ok;
    assign sts.in_clear   = in_op == msapc_pkg::OP_CLEAR;
    assign sts.tally_last = j_wrap && ((CW'(i_reg) + CW'(1)) == cols);
    assign sts.sweep_last = sweep_reg == AW'(msapc_pkg::NUM_COUNTERS - 1);

    // row with the incoming symbol merged in, for the tally start
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            row_new[k] = row_reg[k];
        end
        row_new[fill_reg] = in_symbol;
    end

    // counter read address: tally pair or read request
    always_comb begin
        if (cmd.tally_step) begin
            rd_slot = msapc_pkg::slot(i_reg, j_reg, iscan_reg[0], jscan_reg[0]);
        end else begin
            rd_slot = msapc_pkg::slot(in_col_i, in_col_j, in_sym_a, in_sym_b);
        end
    end
    assign rd_en = (cmd.tally_step || (cmd.accept && read_ok))
                && (rd_slot < msapc_pkg::SLOT_W'(msapc_pkg::NUM_COUNTERS));

    assign wb_data   = (rdata_reg == msapc_pkg::COUNT_MAX) ? rdata_reg
                                                           : rdata_reg + 1'b1;
    assign mem_we    = cmd.sweep_step || wb_valid_reg;
    assign mem_waddr = cmd.sweep_step ? sweep_reg : wb_addr_reg;
    assign mem_wdata = cmd.sweep_step ? '0 : wb_data;

    // counter memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_slot[AW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= msapc_pkg::CFG_RESET;
            fill_reg     <= '0;
            rows_reg     <= '0;
            sweep_reg    <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            wb_valid_reg <= cmd.tally_step && rd_en;
            if (cmd.sweep_step) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.accept && sts.in_clear) begin
                fill_reg  <= '0;
                rows_reg  <= '0;
                sweep_reg <= '0;
            end
            if (cmd.accept && push_ok) begin
                fill_reg <= push_done ? '0 : fill_reg + 1'b1;
                if (push_done && (rows_reg != msapc_pkg::ROWS_MAX)) begin
                    rows_reg <= rows_reg + 1'b1;
                end
            end
        end
    end

    // row buffer, scan lines and pair counters
    always_ff @(posedge aclk) begin
        wb_addr_reg <= rd_slot[AW-1:0];
        if (cmd.accept && push_ok) begin
            row_reg[fill_reg] <= in_symbol;
        end
        if (cmd.accept && sts.in_tally) begin
            i_reg <= '0;
            j_reg <= '0;
            for (int k = 0; k < NC; k++) begin
                iscan_reg[k] <= row_new[k];
                jscan_reg[k] <= row_new[k];
            end
        end else if (cmd.tally_step) begin
            if (j_wrap) begin
                j_reg <= '0;
                i_reg <= i_reg + 1'b1;
                for (int k = 0; k < NC; k++) begin
                    jscan_reg[k] <= row_reg[k];
                end
                for (int k = 0; k < NC - 1; k++) begin
                    iscan_reg[k] <= iscan_reg[k + 1];
                end
            end else begin
                j_reg <= j_reg + 1'b1;
                for (int k = 0; k < NC - 1; k++) begin
                    jscan_reg[k] <= jscan_reg[k + 1];
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_rows <= rows_reg;
            case (cmd.out_src)
                msapc_pkg::SRC_NOW: begin
                    out_count    <= '0;
                    out_complete <= 1'b0;
                    out_error    <= err_now;
                end
                msapc_pkg::SRC_READ: begin
                    out_count    <= rdata_reg[msapc_pkg::VAL_W-1:0];
                    out_complete <= 1'b0;
                    out_error    <= 1'b0;
                end
                msapc_pkg::SRC_TALLY: begin
                    out_count    <= '0;
                    out_complete <= 1'b1;
                    out_error    <= 1'b0;
                end
                default: begin
                    out_count    <= '0;
                    out_complete <= 1'b0;
                    out_error    <= 1'b0;
                end
            endcase
        end
    end

endmodule
